@@ rtl/aswr_pkg.sv @@
// shared types and constants for the array stack with reverse
`timescale 1ns / 1ps
`default_nettype none

package aswr_pkg;

    // default stack depth and field widths
    localparam int DEPTH_DEF   = 128;
    localparam int WORD_W      = 32;
    localparam int DEPTH_NOW_W = 8;

    // operation codes on s_func
    typedef enum logic [1:0] {
        FN_PUSH    = 2'd0,
        FN_POP     = 2'd1,
        FN_PEEK    = 2'd2,
        FN_REVERSE = 2'd3
    } func_t;

    // result status codes on m_status
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

endpackage

`default_nettype wire

@@ rtl/aswr_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module aswr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/array_stack_with_reverse_top.sv @@
// lifo stack of signed words with push, pop, peek and in-place reverse
//
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    s_func[1:0], s_push_value[31:0]
//  m_       out  m_valid/m_ready    m_read_value[31:0], m_status[1:0], m_depth_now[7:0]
//
// push, and any operation on an empty stack, has its result registered in the cycle after the beat.
// pop and peek make one read of the stack ram, whose read data is registered, then load the result.
// reverse swaps mirrored entries from the outside in: each swap of mirrored entries
// needs two reads and two writes through the single ram port pair.
// s_ready is low while an operation runs and while an untaken result would block.
// aresetn is synchronous, active low; it empties the stack, ram contents stay as they are.
`timescale 1ns / 1ps
`default_nettype none

module array_stack_with_reverse_top
    import aswr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_func,
    input  wire logic signed [WORD_W-1:0] s_push_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [WORD_W-1:0]      m_read_value,
    output logic [1:0]                    m_status,
    output logic [DEPTH_NOW_W-1:0]        m_depth_now
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SW_RD_LO,
        S_SW_RD_HI,
        S_SW_WR_LO,
        S_SW_WR_HI
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [AW-1:0]        lo_reg, lo_next;
    logic [AW-1:0]        hi_reg, hi_next;
    logic [WORD_W-1:0]    lo_data_reg, lo_data_next;
    logic                 m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]    m_read_value_reg, m_read_value_next;
    status_t              m_status_reg, m_status_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [CW-1:0]        fill_dec;
    logic [CW-1:0]        fill_inc;
    logic [AW:0]          gap;
    logic [CW+DEPTH_NOW_W-1:0] fill_ext;

    // stack storage
    aswr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake and fill level helpers
    assign s_ready  = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign full     = (fill_reg == CW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign fill_dec = fill_reg - 1'b1;
    assign fill_inc = fill_reg + 1'b1;
    assign gap      = {1'b0, hi_reg} - {1'b0, lo_reg};
    assign fill_ext = {{DEPTH_NOW_W{1'b0}}, fill_reg};

    // sequencer next state, ram control and result load
    always_comb begin
        state_next        = state_reg;
        fill_next         = fill_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        lo_data_next      = lo_data_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_read_value_next = m_read_value_reg;
        m_status_next     = m_status_reg;
        ram_we            = 1'b0;
        ram_waddr         = lo_reg;
        ram_wdata         = ram_rdata;
        ram_raddr         = lo_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (func_t'(s_func))
                        FN_PUSH: begin
                            m_valid_next      = 1'b1;
                            m_read_value_next = '0;
                            if (full) begin
                                m_status_next = ST_OVERFLOW;
                            end else begin
                                ram_we        = 1'b1;
                                ram_waddr     = fill_reg[AW-1:0];
                                ram_wdata     = s_push_value;
                                fill_next     = fill_inc;
                                m_status_next = ST_OK;
                            end
                        end
                        FN_POP: begin
                            if (empty) begin
                                m_valid_next      = 1'b1;
                                m_read_value_next = '1;
                                m_status_next     = ST_UNDERFLOW;
                            end else begin
                                fill_next  = fill_dec;
                                ram_raddr  = fill_dec[AW-1:0];
                                state_next = S_RD_WAIT;
                            end
                        end
                        FN_PEEK: begin
                            if (empty) begin
                                m_valid_next      = 1'b1;
                                m_read_value_next = '0;
                                m_status_next     = ST_EMPTY;
                            end else begin
                                ram_raddr  = fill_dec[AW-1:0];
                                state_next = S_RD_WAIT;
                            end
                        end
                        default: begin
                            // reverse: nothing to swap with fewer than two entries
                            if (fill_reg <= CW'(1)) begin
                                m_valid_next      = 1'b1;
                                m_read_value_next = '0;
                                m_status_next     = ST_OK;
                            end else begin
                                lo_next    = '0;
                                hi_next    = fill_dec[AW-1:0];
                                state_next = S_SW_RD_LO;
                            end
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                m_valid_next      = 1'b1;
                m_read_value_next = ram_rdata;
                m_status_next     = ST_OK;
                state_next        = S_IDLE;
            end
            S_SW_RD_LO: begin
                ram_raddr  = lo_reg;
                state_next = S_SW_RD_HI;
            end
            S_SW_RD_HI: begin
                ram_raddr    = hi_reg;
                lo_data_next = ram_rdata;
                state_next   = S_SW_WR_LO;
            end
            S_SW_WR_LO: begin
                // upper word arrives now and goes to the lower slot
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = ram_rdata;
                state_next = S_SW_WR_HI;
            end
            S_SW_WR_HI: begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = lo_data_reg;
                lo_next   = lo_reg + 1'b1;
                hi_next   = hi_reg - 1'b1;
                if (gap > (AW+1)'(2)) begin
                    state_next = S_SW_RD_LO;
                end else begin
                    m_valid_next      = 1'b1;
                    m_read_value_next = '0;
                    m_status_next     = ST_OK;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
        lo_reg           <= lo_next;
        hi_reg           <= hi_next;
        lo_data_reg      <= lo_data_next;
        m_read_value_reg <= m_read_value_next;
        m_status_reg     <= m_status_next;
    end

    // result beat; fill level only moves once the previous result is taken
    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_depth_now  = fill_ext[DEPTH_NOW_W-1:0];

`ifndef SYNTHESIS
    // fill level never passes the depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(DEPTH))
        else $error("stack fill level above depth");

    // swap pointers stay ordered while reversing
    a_swap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SW_RD_LO || state_reg == S_SW_RD_HI ||
         state_reg == S_SW_WR_LO || state_reg == S_SW_WR_HI) |-> (lo_reg < hi_reg))
        else $error("reverse pointers crossed");

    // a push beat on a non-full stack grows it by one
    a_push_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_func == FN_PUSH && !full) |=> (fill_reg == $past(fill_inc)))
        else $error("push did not grow the stack");

    // a busy sequencer never takes a new beat
    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input taken while busy");
`endif

endmodule

`default_nettype wire

@@ bench/aswr_stack_checker.sv @@
// checker that predicts and compares every result beat of the array stack
`timescale 1ns / 1ps

module aswr_stack_checker
    import aswr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  wire logic [1:0]               s_func,
    input  wire logic signed [WORD_W-1:0] s_push_value,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire logic signed [WORD_W-1:0] m_read_value,
    input  wire logic [1:0]               m_status,
    input  wire logic [DEPTH_NOW_W-1:0]   m_depth_now,
    output int                            mismatches,
    output int                            outstanding,
    output int                            results_seen,
    output int                            overflows_seen,
    output int                            underflows_seen,
    output int                            empties_seen
);

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        status_t                  status;
        logic [DEPTH_NOW_W-1:0]   depth_now;
    } stack_result_t;

    // shadow copy of the stack contents and fill level
    logic signed [WORD_W-1:0] shadow_stack [DEPTH];
    int unsigned              shadow_fill = 0;
    stack_result_t            due_results [$];

    int err_cnt = 0;
    int got_cnt = 0;
    int ovf_cnt = 0;
    int unf_cnt = 0;
    int emp_cnt = 0;

    // apply one operation to the shadow stack and return its result
    function automatic stack_result_t apply_stack_op(func_t op,
                                                     logic signed [WORD_W-1:0] word);
        stack_result_t            res;
        logic signed [WORD_W-1:0] swap_word;
        int unsigned              lo;
        int unsigned              hi;
        res.read_value = '0;
        res.status     = ST_OK;
        case (op)
            FN_PUSH: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    shadow_stack[shadow_fill] = word;
                    shadow_fill++;
                end
            end
            FN_POP: begin
                if (shadow_fill == 0) begin
                    res.read_value = -1;
                    res.status     = ST_UNDERFLOW;
                end else begin
                    shadow_fill--;
                    res.read_value = shadow_stack[shadow_fill];
                end
            end
            FN_PEEK: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_value = shadow_stack[shadow_fill - 1];
                end
            end
            default: begin
                // swap mirrored entries from the outside in
                lo = 0;
                hi = shadow_fill;
                while (hi > lo + 1) begin
                    hi--;
                    swap_word        = shadow_stack[lo];
                    shadow_stack[lo] = shadow_stack[hi];
                    shadow_stack[hi] = swap_word;
                    lo++;
                end
            end
        endcase
        res.depth_now = shadow_fill[DEPTH_NOW_W-1:0];
        return res;
    endfunction

    // watch both channels, compare result beats, then predict input beats
    always @(posedge aclk) begin
        stack_result_t want;
        if (!aresetn) begin
            shadow_fill = 0;
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got_cnt++;
                if (due_results.size() == 0) begin
                    $error("result beat with no expected result: read_value %0d status %0d",
                           m_read_value, m_status);
                    err_cnt++;
                end else begin
                    want = due_results.pop_front();
                    if (m_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, actual %0d",
                               want.read_value, m_read_value);
                        err_cnt++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        err_cnt++;
                    end
                    if (m_depth_now !== want.depth_now) begin
                        $error("depth_now: expected %0d, actual %0d",
                               want.depth_now, m_depth_now);
                        err_cnt++;
                    end
                    case (want.status)
                        ST_OVERFLOW:  ovf_cnt++;
                        ST_UNDERFLOW: unf_cnt++;
                        ST_EMPTY:     emp_cnt++;
                        default:      ;
                    endcase
                end
            end
            if (s_valid && s_ready) begin
                due_results.push_back(apply_stack_op(func_t'(s_func), s_push_value));
            end
        end
        mismatches      <= err_cnt;
        outstanding     <= due_results.size();
        results_seen    <= got_cnt;
        overflows_seen  <= ovf_cnt;
        underflows_seen <= unf_cnt;
        empties_seen    <= emp_cnt;
    end

endmodule

@@ bench/tb_array_stack_with_reverse_top.sv @@
// testbench top for the array stack: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_array_stack_with_reverse_top;
    import aswr_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int RAND_OPS       = 1100;
    localparam int CALM_FROM      = RAND_OPS - 150;
    localparam int DRAIN_CYCLES   = 1 + 4 * (DEPTH / 2) + 8;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                     aclk         = 1'b0;
    logic                     aresetn      = 1'b0;
    logic                     s_valid      = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_func       = FN_PEEK;
    logic signed [WORD_W-1:0] s_push_value = '0;
    logic                     m_valid;
    logic                     m_ready      = 1'b0;
    logic signed [WORD_W-1:0] m_read_value;
    logic [1:0]               m_status;
    logic [DEPTH_NOW_W-1:0]   m_depth_now;

    int mismatches;
    int outstanding;
    int results_seen;
    int overflows_seen;
    int underflows_seen;
    int empties_seen;

    logic idle_on      = 1'b0;
    int   stall_left   = 0;
    int   quiet_cycles = 0;
    int   ops_sent     = 0;
    int   reverses     = 0;
    int   level        = 0;

    always #5 aclk = ~aclk;

    array_stack_with_reverse_top #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_depth_now  (m_depth_now)
    );

    aswr_stack_checker #(
        .DEPTH(DEPTH)
    ) stack_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_push_value    (s_push_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_value    (m_read_value),
        .m_status        (m_status),
        .m_depth_now     (m_depth_now),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_seen    (results_seen),
        .overflows_seen  (overflows_seen),
        .underflows_seen (underflows_seen),
        .empties_seen    (empties_seen)
    );

    // result side backpressure in random bursts while idle_on is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // end the run if no beat moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("** array_stack_with_reverse_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // push word: mostly random, sometimes an extreme
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // offer one input beat, with an optional idle burst first
    task automatic send_op(input func_t op, input logic [WORD_W-1:0] word);
        bit took;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= op;
        s_push_value <= word;
        // ready is settled mid-cycle and holds through the coming edge
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        ops_sent++;
        case (op)
            FN_PUSH:    if (level < DEPTH) level++;
            FN_POP:     if (level > 0) level--;
            FN_REVERSE: reverses++;
            default:    ;
        endcase
    endtask

    initial begin
        int    n;
        int    pick;
        bit    filling;
        func_t op;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cases, extremes, reverse on 0, 1, 2 and 5 entries
        idle_on <= 1'b1;
        send_op(FN_PEEK, 32'h1234_5678);
        send_op(FN_POP, 32'hffff_ffff);
        send_op(FN_REVERSE, 32'h0);
        send_op(FN_PUSH, 32'h7fff_ffff);
        send_op(FN_REVERSE, 32'h8000_0000);
        send_op(FN_PEEK, 32'h0);
        send_op(FN_PUSH, 32'h8000_0000);
        send_op(FN_PUSH, 32'h0000_0000);
        send_op(FN_PUSH, 32'hffff_ffff);
        send_op(FN_PUSH, 32'h0000_0001);
        send_op(FN_PEEK, 32'h0);
        send_op(FN_REVERSE, 32'h0);
        send_op(FN_PEEK, 32'h0);
        send_op(FN_POP, 32'h0);
        send_op(FN_POP, 32'h0);
        send_op(FN_POP, 32'h0);
        send_op(FN_REVERSE, 32'h0);
        send_op(FN_POP, 32'h0);
        send_op(FN_POP, 32'h0);
        send_op(FN_POP, 32'h0);
        send_op(FN_PEEK, 32'h0);
        send_op(FN_PUSH, 32'haaaa_aaaa);
        send_op(FN_PUSH, 32'h5555_5555);
        send_op(FN_POP, 32'h0);
        send_op(FN_POP, 32'h0);

        // random: alternate fill and drain runs so full and empty are both hit
        filling = 1'b1;
        for (n = 0; n < RAND_OPS; n++) begin
            if (n == CALM_FROM) begin
                idle_on <= 1'b0;
            end else if (n < CALM_FROM && n % 100 == 0) begin
                idle_on <= ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                op = func_t'($urandom_range(0, 3));
            end else if (pick < 12) begin
                op = FN_REVERSE;
            end else if (pick < 20) begin
                op = FN_PEEK;
            end else if (filling) begin
                op = (pick < 32) ? FN_POP : FN_PUSH;
            end else begin
                op = (pick < 76) ? FN_POP : FN_PUSH;
            end
            send_op(op, pick_word());
            if (filling && level == DEPTH && $urandom_range(0, 3) == 0) begin
                filling = 1'b0;
            end else if (!filling && level == 0 && $urandom_range(0, 3) == 0) begin
                filling = 1'b1;
            end else if ($urandom_range(0, 79) == 0) begin
                filling = !filling;
            end
        end

        // drain and let any late beat show up
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d operations and %0d results, %0d of them reverses",
                 ops_sent, results_seen, reverses);
        $display("full-stack pushes %0d, empty pops %0d, empty peeks %0d, mismatches %0d",
                 overflows_seen, underflows_seen, empties_seen, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** array_stack_with_reverse_top: PASSED **");
        end else begin
            $display("** array_stack_with_reverse_top: FAILED **");
        end
        $finish;
    end

endmodule
